FILE: design/smx_pkg.sv
// smx_pkg: shared types, sizes and codes of the stack machine executor
// used by every module of the block and by its port checker
`default_nettype none

package smx_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int CNT_W       = 7;
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SUM_W       = CNT_W + 1;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CMD_W-1:0]         cmd_t;
    typedef logic [1:0]               kind_t;
    typedef logic [1:0]               status_t;
    typedef logic [CNT_W-1:0]         count_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [1:0]               shift_t;

    localparam cmd_t CMD_PUSH = 3'd0;
    localparam cmd_t CMD_POP  = 3'd1;
    localparam cmd_t CMD_ADD  = 3'd2;
    localparam cmd_t CMD_PUTS = 3'd3;
    localparam cmd_t CMD_DUMP = 3'd4;
    localparam cmd_t CMD_DUP  = 3'd5;

    localparam kind_t KIND_ACK   = 2'd0;
    localparam kind_t KIND_TOP   = 2'd1;
    localparam kind_t KIND_ENTRY = 2'd2;
    localparam kind_t KIND_EMPTY = 2'd3;

    localparam status_t STAT_OK      = 2'd0;
    localparam status_t STAT_UNDER   = 2'd1;
    localparam status_t STAT_OVER    = 2'd2;
    localparam status_t STAT_UNKNOWN = 2'd3;

    // chain moves: toward the tail (push side) or toward the head (pop side)
    localparam shift_t SH_HOLD = 2'd0;
    localparam shift_t SH_DOWN = 2'd1;
    localparam shift_t SH_UP   = 2'd2;

endpackage

`default_nettype wire

FILE: design/smx_cell.sv
// smx_cell: one stack entry, loaded from either neighbor of the chain
// depends on smx_pkg
`default_nettype none

module smx_cell (
    input  wire             aclk,
    input  smx_pkg::shift_t op,
    input  smx_pkg::data_t  up_in,
    input  smx_pkg::data_t  down_in,
    output smx_pkg::data_t  q
);
    import smx_pkg::*;

    data_t q_reg;
    data_t q_next;

    always_comb begin
        q_next = q_reg;
        case (op)
            SH_DOWN: q_next = up_in;
            SH_UP:   q_next = down_in;
            default: q_next = q_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

FILE: design/smx_chain.sv
// smx_chain: row of smx_cell, cell 0 holds the top of the stack
// depends on smx_pkg and smx_cell
`default_nettype none

module smx_chain (
    input  wire             aclk,
    input  smx_pkg::shift_t op,
    input  smx_pkg::data_t  head_up,
    input  smx_pkg::data_t  head_down,
    output smx_pkg::data_t  top,
    output smx_pkg::data_t  second,
    output smx_pkg::data_t  tail
);
    import smx_pkg::*;

    data_t q [STACK_DEPTH];

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        data_t up_in;
        data_t down_in;

        if (i == 0) begin : g_head
            assign up_in   = head_up;
            assign down_in = head_down;
        end else if (i == STACK_DEPTH - 1) begin : g_tail
            assign up_in   = q[i-1];
            assign down_in = q[i];
        end else begin : g_mid
            assign up_in   = q[i-1];
            assign down_in = q[i+1];
        end

        smx_cell u_cell (
            .aclk    (aclk),
            .op      (op),
            .up_in   (up_in),
            .down_in (down_in),
            .q       (q[i])
        );
    end

    assign top    = q[0];
    assign second = q[1];
    assign tail   = q[STACK_DEPTH-1];

endmodule

`default_nettype wire

FILE: design/stack_machine_executor_core.sv
// stack_machine_executor_core: input buffer, command sequencer and result register
// around the cell chain; depends on smx_pkg and smx_chain
//
// Usage:
//   s_ channel takes one instruction per transaction (s_command, s_operand).
//   m_ channel gives the results (m_kind, m_value, m_status, m_last, m_depth);
//   m_last marks the final result of an instruction.
//   The stack lives in a chain of STACK_DEPTH cells with the top in cell 0;
//   push, pop, add, puts and dup shift the whole chain by one place at once.
//   An instruction waits in the input buffer, and its result in the result register.
//   Throughput: one instruction per cycle for everything but dump, while m_ready stays high.
//   A non-empty dump rotates the chain through all STACK_DEPTH cells,
//   sending the tail cell out when it holds a live entry, and occupies the
//   sequencer until the rotation ends, longer when the output stalls.
//   A one-entry input buffer takes the next instruction while a result
//   waits or a dump runs.
//   When m_ready is low the result register holds and the sequencer waits;
//   the chain does not move until the pending result is taken.
//   Reset empties the stack and drops any buffered instruction or result.
`default_nettype none

module stack_machine_executor_core (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  smx_pkg::cmd_t     s_command,
    input  smx_pkg::data_t    s_operand,
    output logic              m_valid,
    input  wire               m_ready,
    output smx_pkg::kind_t    m_kind,
    output smx_pkg::data_t    m_value,
    output smx_pkg::status_t  m_status,
    output logic              m_last,
    output smx_pkg::count_t   m_depth
);
    import smx_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    localparam count_t FULL_CNT  = CNT_W'(STACK_DEPTH);
    localparam idx_t   LAST_STEP = IDX_W'(STACK_DEPTH - 1);

    logic    state_reg,    state_next;
    logic    in_valid_reg, in_valid_next;
    cmd_t    cmd_reg;
    data_t   opnd_reg;
    count_t  count_reg,    count_next;
    idx_t    step_reg,     step_next;

    logic    m_valid_reg,  m_valid_next;
    kind_t   m_kind_reg,   m_kind_next;
    data_t   m_value_reg,  m_value_next;
    status_t m_status_reg, m_status_next;
    logic    m_last_reg,   m_last_next;
    count_t  m_depth_reg,  m_depth_next;

    shift_t  chain_op;
    data_t   head_up;
    data_t   head_down;
    data_t   top;
    data_t   second;
    data_t   tail;

    logic    out_free;
    logic    consume;
    logic    is_empty;
    logic    is_full;
    logic    dump_emit;

    smx_chain u_chain (
        .aclk      (aclk),
        .op        (chain_op),
        .head_up   (head_up),
        .head_down (head_down),
        .top       (top),
        .second    (second),
        .tail      (tail)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign consume   = in_valid_reg && (state_reg == ST_IDLE) && out_free;
    assign s_ready   = !in_valid_reg || ((state_reg == ST_IDLE) && out_free);
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == FULL_CNT);
    // tail holds a live entry once enough of the dead cells have rotated past
    assign dump_emit = (SUM_W'(step_reg) + SUM_W'(count_reg)) >= SUM_W'(STACK_DEPTH);

    // rotation feeds the tail back to the head during dump
    assign head_up   = (state_reg == ST_DUMP) ? tail :
                       ((cmd_reg == CMD_DUP) ? top : opnd_reg);
    assign head_down = (cmd_reg == CMD_ADD) ? data_t'(top + second) : second;

    always_comb begin
        state_next    = state_reg;
        in_valid_next = in_valid_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        chain_op      = SH_HOLD;
        m_valid_next  = m_valid_reg;
        m_kind_next   = m_kind_reg;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        m_depth_next  = m_depth_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (consume) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (consume) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_ACK;
                    m_value_next  = '0;
                    m_status_next = STAT_OK;
                    m_last_next   = 1'b1;
                    unique case (cmd_reg)
                        CMD_PUSH: begin
                            if (is_full) begin
                                m_status_next = STAT_OVER;
                            end else begin
                                chain_op   = SH_DOWN;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_POP: begin
                            if (is_empty) begin
                                m_status_next = STAT_UNDER;
                            end else begin
                                chain_op   = SH_UP;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_ADD: begin
                            if (count_reg < CNT_W'(2)) begin
                                m_status_next = STAT_UNDER;
                            end else begin
                                chain_op   = SH_UP;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_PUTS: begin
                            if (is_empty) begin
                                m_status_next = STAT_UNDER;
                            end else begin
                                m_kind_next  = KIND_TOP;
                                m_value_next = top;
                                chain_op     = SH_UP;
                                count_next   = count_reg - 1'b1;
                            end
                        end
                        CMD_DUMP: begin
                            if (is_empty) begin
                                m_kind_next = KIND_EMPTY;
                            end else begin
                                m_valid_next = 1'b0;
                                state_next   = ST_DUMP;
                                step_next    = '0;
                            end
                        end
                        CMD_DUP: begin
                            if (is_empty) begin
                                m_status_next = STAT_UNDER;
                            end else if (is_full) begin
                                m_status_next = STAT_OVER;
                            end else begin
                                chain_op   = SH_DOWN;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        default: begin
                            m_status_next = STAT_UNKNOWN;
                        end
                    endcase
                    m_depth_next = count_next;
                end
            end
            ST_DUMP: begin
                if (!dump_emit || out_free) begin
                    chain_op  = SH_DOWN;
                    step_next = idx_t'(step_reg + 1'b1);
                    if (dump_emit) begin
                        m_valid_next  = 1'b1;
                        m_kind_next   = KIND_ENTRY;
                        m_value_next  = tail;
                        m_status_next = STAT_OK;
                        m_last_next   = (step_reg == LAST_STEP);
                        m_depth_next  = count_reg;
                    end
                    if (step_reg == LAST_STEP) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_valid_reg <= 1'b0;
            count_reg    <= '0;
            step_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_valid_reg <= in_valid_next;
            count_reg    <= count_next;
            step_reg     <= step_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg  <= s_command;
            opnd_reg <= s_operand;
        end
        m_kind_reg   <= m_kind_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
        m_depth_reg  <= m_depth_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_kind   = m_kind_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;
    assign m_last   = m_last_reg;
    assign m_depth  = m_depth_reg;

endmodule

`default_nettype wire

FILE: design/smx_checker.sv
// smx_checker: port-level checks on the result channel of the executor core
// depends on smx_pkg; bound to stack_machine_executor_core below
`default_nettype none

module smx_checker (
    input wire               aclk,
    input wire               aresetn,
    input wire               m_valid,
    input wire               m_ready,
    input smx_pkg::kind_t    m_kind,
    input smx_pkg::data_t    m_value,
    input smx_pkg::status_t  m_status,
    input wire               m_last,
    input smx_pkg::count_t   m_depth
);
    import smx_pkg::*;

    // a stalled transaction keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_value)
            && $stable(m_status) && $stable(m_last) && $stable(m_depth))
        else $error("result changed while stalled");

    // a failed instruction gives a lone zero acknowledgment
    a_err_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STAT_OK) |->
            m_last && (m_kind == KIND_ACK) && (m_value == '0))
        else $error("error result is not a plain acknowledgment");

    // empty dump only when the stack is empty
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_EMPTY) |-> m_last && (m_depth == '0))
        else $error("empty dump with a non-empty stack");

    // dump entries carry an OK status and never come from an empty stack
    a_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_ENTRY) |->
            (m_status == STAT_OK) && (m_depth != '0))
        else $error("dump entry with bad status or depth");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_depth <= CNT_W'(STACK_DEPTH))
        else $error("depth beyond stack size");

endmodule

bind stack_machine_executor_core smx_checker u_smx_checker (.*);

`default_nettype wire
